### rtl/core/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants and types for the chained hash table unit.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int NUM_BUCKETS  = 256;
    localparam int BUCKET_DEPTH = 8;
    localparam int KEY_W        = 32;
    localparam int TS_W         = 9;
    localparam int TS_RESET     = 256;

    localparam int DIV_W = ($clog2(NUM_BUCKETS + 1) > TS_W) ? $clog2(NUM_BUCKETS + 1) : TS_W;
    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W = $clog2(BUCKET_DEPTH + 1);

    localparam int ENTRY_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W      = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

    // remainder unit retires two dividend bits per cycle
    localparam int DIV_STEPS = KEY_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic found;
        logic status;
    } t_result;

endpackage

### rtl/core/chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// Hash table with separate chaining: insert or search of 32-bit keys, the
// bucket being the key modulo the programmed table size clamped to 1..256.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     push / full               i_func, i_key
//  result    empty / pop               o_found, o_status
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (table size)
//
//  The front takes no new transaction until the last is handed off; full is
//  held during the remainder unit (two key bits per cycle) and the hand-off.
//  The back takes an insert through count lookup and result hand-off, and a
//  search through a bucket walk too, one stored key per cycle from entry RAM.
//  Reset clears the bucket count valid bits at once; no clearing pass.
//  A two-entry queue sits between front and back and another on the result
//  side, so either end may stall without blocking the other.
// ----------------------------------------------------------------------------
module chained_hash_table_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_func,
    input  logic [cht_pkg::KEY_W-1:0]  i_key,
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_found,
    output logic                       o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cht_pkg::TS_W-1:0]   i_cfg_data
);
    import cht_pkg::*;

    logic [TS_W-1:0]  r_tbl_sz;
    logic [DIV_W-1:0] ts_ext, divisor;

    logic job_push, job_full, job_pop, job_empty;
    t_job job_in, job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_sz <= TS_W'(TS_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tbl_sz <= i_cfg_data;
        end
    end

    assign ts_ext = DIV_W'(r_tbl_sz);

    always_comb begin
        priority if (ts_ext == '0) begin
            divisor = DIV_W'(1);
        end else if (ts_ext > DIV_W'(NUM_BUCKETS)) begin
            divisor = DIV_W'(NUM_BUCKETS);
        end else begin
            divisor = ts_ext;
        end
    end

    cht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_func     (i_func),
        .i_key      (i_key),
        .i_div      (divisor),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    cht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    cht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_found     (o_found),
        .o_status    (o_status)
    );

endmodule

### rtl/core/cht_ram.sv
// ----------------------------------------------------------------------------
// cht_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cht_front.sv
// ----------------------------------------------------------------------------
// cht_front
// Input stage: accepts a transaction and computes its bucket as key modulo
// the divisor with a radix-4 restoring remainder unit.
// ----------------------------------------------------------------------------
module cht_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_func,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  logic [cht_pkg::DIV_W-1:0] i_div,
    output logic                     o_job_push,
    output cht_pkg::t_job            o_job,
    input  logic                     i_job_full
);
    import cht_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DIV_W-1:0] r_div, n_div;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [KEY_W-1:0] r_dvd, n_dvd;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_func, n_func;

    logic [DIV_W:0]   rem_a, sub_a, rem_b, sub_b;
    logic [DIV_W-1:0] rem_a_q, rem_b_q;

    always_comb begin
        rem_a   = {r_rem, r_dvd[KEY_W-1]};
        sub_a   = rem_a - {1'b0, r_div};
        rem_a_q = (rem_a >= {1'b0, r_div}) ? sub_a[DIV_W-1:0] : rem_a[DIV_W-1:0];
        rem_b   = {rem_a_q, r_dvd[KEY_W-2]};
        sub_b   = rem_b - {1'b0, r_div};
        rem_b_q = (rem_b >= {1'b0, r_div}) ? sub_b[DIV_W-1:0] : rem_b[DIV_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_div   = r_div;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_key   = r_key;
        n_func  = r_func;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_dvd   = i_key;
                    n_key   = i_key;
                    n_func  = i_func;
                    n_div   = i_div;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_rem  = rem_b_q;
                n_dvd  = r_dvd << 2;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_key  <= n_key;
        r_func <= n_func;
    end

    assign o_full       = (r_state != F_IDLE);
    assign o_job_push   = (r_state == F_PUSH);
    assign o_job.func   = r_func;
    assign o_job.key    = r_key;
    assign o_job.bucket = r_rem[BKT_W-1:0];

endmodule

### rtl/core/cht_queue.sv
// ----------------------------------------------------------------------------
// cht_queue
// Two-entry job queue between the front and back stages.
// ----------------------------------------------------------------------------
module cht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cht_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output cht_pkg::t_job o_data,
    output logic          o_empty
);
    import cht_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/core/cht_back.sv
// ----------------------------------------------------------------------------
// cht_back
// Execution stage: bucket count lookup, insert write or bucket walk for a
// search, and a two-entry result queue.
// ----------------------------------------------------------------------------
module cht_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cht_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic          o_found,
    output logic          o_status
);
    import cht_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_CNT  = 2'd1;
    localparam logic [1:0] B_SRCH = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    t_job             r_job, n_job;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_slot, n_slot;
    logic             r_found, n_found;
    t_result          r_res, n_res;
    logic [NUM_BUCKETS-1:0] r_cnt_vld;

    logic             cnt_we;
    logic [CNT_W-1:0] cnt_rdata, cnt_cur;
    logic             ent_we, ent_re;
    logic [CNT_W-1:0] rd_slot, slot_nx;
    logic [ADDR_W-1:0] base;
    logic [KEY_W-1:0] ent_rdata;
    logic             hit;

    t_result    r_rq [2];
    logic       r_rq_wp, r_rq_rp;
    logic [1:0] r_rq_cnt;
    logic       rq_push, rq_full, rq_pop;

    assign cnt_cur = r_cnt_vld[r_job.bucket] ? cnt_rdata : '0;
    assign base    = ADDR_W'(r_job.bucket) * ADDR_W'(BUCKET_DEPTH);
    assign hit     = (ent_rdata == r_job.key);
    assign slot_nx = r_slot + 1'b1;

    cht_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_job.bucket),
        .i_wdata (cnt_cur + 1'b1),
        .i_re    (o_job_pop),
        .i_raddr (i_job.bucket),
        .o_rdata (cnt_rdata)
    );

    cht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRY_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (base + ADDR_W'(cnt_cur)),
        .i_wdata (r_job.key),
        .i_re    (ent_re),
        .i_raddr (base + ADDR_W'(rd_slot)),
        .o_rdata (ent_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_found   = r_found;
        n_res     = r_res;
        o_job_pop = 1'b0;
        cnt_we    = 1'b0;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        rd_slot   = '0;
        rq_push   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_state   = B_CNT;
                end
            end
            B_CNT: begin
                if (r_job.func == FUNC_INSERT) begin
                    if (cnt_cur >= CNT_W'(BUCKET_DEPTH)) begin
                        n_res = '{found: 1'b0, status: 1'b1};
                    end else begin
                        cnt_we = 1'b1;
                        ent_we = 1'b1;
                        n_res  = '{found: 1'b0, status: 1'b0};
                    end
                    n_state = B_OUT;
                end else if (cnt_cur == '0) begin
                    n_res   = '{found: 1'b0, status: 1'b0};
                    n_state = B_OUT;
                end else begin
                    ent_re  = 1'b1;
                    rd_slot = '0;
                    n_slot  = '0;
                    n_cnt   = cnt_cur;
                    n_found = 1'b0;
                    n_state = B_SRCH;
                end
            end
            B_SRCH: begin
                if (slot_nx < r_cnt) begin
                    ent_re  = 1'b1;
                    rd_slot = slot_nx;
                    n_slot  = slot_nx;
                    n_found = r_found | hit;
                end else begin
                    n_res   = '{found: r_found | hit, status: 1'b0};
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!rq_full) begin
                    rq_push = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_cnt_vld <= '0;
        end else begin
            r_state <= n_state;
            if (cnt_we) begin
                r_cnt_vld[r_job.bucket] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_cnt   <= n_cnt;
        r_slot  <= n_slot;
        r_found <= n_found;
        r_res   <= n_res;
    end

    assign rq_full  = (r_rq_cnt == 2'd2);
    assign o_empty  = (r_rq_cnt == 2'd0);
    assign rq_pop   = i_pop && !o_empty;
    assign o_found  = r_rq[r_rq_rp].found;
    assign o_status = r_rq[r_rq_rp].status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= 1'b0;
            r_rq_rp  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (rq_push) begin
                r_rq_wp <= ~r_rq_wp;
            end
            if (rq_pop) begin
                r_rq_rp <= ~r_rq_rp;
            end
            r_rq_cnt <= r_rq_cnt + {1'b0, rq_push} - {1'b0, rq_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rq_push) begin
            r_rq[r_rq_wp] <= r_res;
        end
    end

endmodule
